// ===== rtl/core/poterm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package poterm_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps = 31;
  localparam logic [31:0] CordicGainInv = 32'd652032874;

  localparam logic [0:0] RegOffsetL = 1'b0;
  localparam logic [0:0] RegOffsetM = 1'b1;

  typedef struct packed {
    logic signed [31:0] dir_l;
    logic signed [31:0] dir_m;
    logic signed [31:0] shift_l;
    logic signed [31:0] shift_m;
    logic signed [31:0] base_u;
    logic signed [31:0] base_v;
    logic signed [31:0] base_w;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] gain_real;
    logic signed [15:0] gain_imag;
    logic               beyond_horizon;
  } out_item_t;

  // state handed along the square root chain
  typedef struct packed {
    logic [61:0] rem_a;
    logic [61:0] res_a;
    logic [61:0] rem_b;
    logic [61:0] res_b;
    logic [37:0] pv;
    logic        horizon;
    logic signed [31:0] base_w;
  } sqrt_cell_t;

  // state handed along the rotation chain
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
    logic               horizon;
  } rot_cell_t;

  function automatic logic signed [33:0] turn_atan(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd536870912;
        1: r = 34'sd316933406;
        2: r = 34'sd167458907;
        3: r = 34'sd85004756;
        4: r = 34'sd42667331;
        5: r = 34'sd21354465;
        6: r = 34'sd10679838;
        7: r = 34'sd5340245;
        8: r = 34'sd2670163;
        9: r = 34'sd1335087;
        10: r = 34'sd667544;
        11: r = 34'sd333772;
        12: r = 34'sd166886;
        13: r = 34'sd83443;
        14: r = 34'sd41722;
        default: r = 34'sd20861;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/position_offset_phase_term_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// position offset phase term: per pixel and antenna, the diagonal jones gain
// cos + i sin of 2*pi*(u*dl + v*dm + w*dn) with dn the change of the n
// coordinate under the pixel shift. one item is accepted every cycle while
// out stall is low; the pipeline advances as a whole, so a stall on the
// output holds every stage. there are 1 + 1 + 31 + 1 + 1 + 16 + 1 = 52
// register stages: shifted coordinates, squared radii and planar products,
// the chain of 31 square root cells (one result bit per cell), w*dn, the
// rotation start, the chain of 16 cordic cells and the output register.
// configuration writes are taken at any time and apply to items accepted
// afterward.
module position_offset_phase_term_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire poterm_pkg::in_item_t    in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output poterm_pkg::out_item_t        out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [0:0]                    cfg_index,
  input  wire [31:0]                   cfg_data
);
  localparam int Depth = 2 + poterm_pkg::SqrtSteps + 2 + poterm_pkg::CordicSteps + 1;

  logic en;
  logic [Depth-1:0] vld;
  logic signed [31:0] off_l;
  logic signed [31:0] off_m;

  // whole pipe moves unless the output holds a result that is stalled
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      off_l <= '0;
      off_m <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        poterm_pkg::RegOffsetL: off_l <= cfg_data;
        poterm_pkg::RegOffsetM: off_m <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // stage 1: shifted coordinates
  logic signed [33:0] s1_l, s1_m, s1_lp, s1_mp;
  logic signed [31:0] s1_dl, s1_dm, s1_u, s1_v, s1_w;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_l  <= 34'(in_data.dir_l) + 34'(off_l);
      s1_m  <= 34'(in_data.dir_m) + 34'(off_m);
      s1_lp <= 34'(in_data.dir_l) + 34'(off_l) + 34'(in_data.shift_l);
      s1_mp <= 34'(in_data.dir_m) + 34'(off_m) + 34'(in_data.shift_m);
      s1_dl <= in_data.shift_l;
      s1_dm <= in_data.shift_m;
      s1_u  <= in_data.base_u;
      s1_v  <= in_data.base_v;
      s1_w  <= in_data.base_w;
    end
  end

  // stage 2: squared radii and planar products
  localparam logic signed [33:0] OneQ30 = 34'sd1 << 30;
  logic in0, in1;
  logic [37:0] p_u, p_v;
  logic signed [33:0] l2, m2, lp2, mp2;
  logic [29:0] al, am, alp, amp;

  always_comb begin
    in0 = (s1_l > -OneQ30) && (s1_l < OneQ30) && (s1_m > -OneQ30) && (s1_m < OneQ30);
    in1 = (s1_lp > -OneQ30) && (s1_lp < OneQ30) && (s1_mp > -OneQ30) && (s1_mp < OneQ30);
    l2 = in0 ? s1_l : '0;
    m2 = in0 ? s1_m : '0;
    lp2 = in1 ? s1_lp : '0;
    mp2 = in1 ? s1_mp : '0;
    // magnitudes, below one in q1.30
    al = l2[33] ? 30'(-l2) : l2[29:0];
    am = m2[33] ? 30'(-m2) : m2[29:0];
    alp = lp2[33] ? 30'(-lp2) : lp2[29:0];
    amp = mp2[33] ? 30'(-mp2) : mp2[29:0];
    // only the fraction of a turn survives, so 38 bits of q.38 are enough
    p_u = 38'(s1_u) * 38'(s1_dl);
    p_v = 38'(s1_v) * 38'(s1_dm);
  end

  logic [61:0] s2_r2, s2_r2p;
  logic        s2_in;
  logic [37:0] s2_pv;
  logic signed [31:0] s2_w;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r2  <= 62'(60'(al) * 60'(al)) + 62'(60'(am) * 60'(am));
      s2_r2p <= 62'(60'(alp) * 60'(alp)) + 62'(60'(amp) * 60'(amp));
      s2_in  <= in0 && in1;
      s2_pv  <= p_u + p_v;
      s2_w   <= s1_w;
    end
  end

  // |l| below one so the 30-bit magnitude squares above fit; radius test next
  localparam logic [61:0] OneQ60 = 62'd1 << 60;
  logic ok;
  assign ok = s2_in && (s2_r2 < OneQ60) && (s2_r2p < OneQ60);

  poterm_pkg::sqrt_cell_t sq [0:poterm_pkg::SqrtSteps];

  always_comb begin
    sq[0].rem_a = ok ? OneQ60 - s2_r2p : '0;
    sq[0].res_a = '0;
    sq[0].rem_b = ok ? OneQ60 - s2_r2 : '0;
    sq[0].res_b = '0;
    sq[0].pv = s2_pv;
    sq[0].horizon = !ok;
    sq[0].base_w = s2_w;
  end

  for (genvar g = 0; g < poterm_pkg::SqrtSteps; g++) begin : g_sqrt
    poterm_sqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .en(en), .din(sq[g]), .dout(sq[g+1])
    );
  end

  // dn and w*dn
  logic signed [31:0] dn;
  assign dn = 32'(sq[poterm_pkg::SqrtSteps].res_a[30:0])
            - 32'(sq[poterm_pkg::SqrtSteps].res_b[30:0]);

  logic [37:0] s3_pw;
  logic [37:0] s3_pv;
  logic s3_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pw <= 38'(sq[poterm_pkg::SqrtSteps].base_w) * 38'(dn);
      s3_pv <= sq[poterm_pkg::SqrtSteps].pv;
      s3_h  <= sq[poterm_pkg::SqrtSteps].horizon;
    end
  end

  // phase sum modulo one turn, rounded to q0.32
  logic [37:0] acc;
  logic [37:0] accr;
  logic [31:0] t;
  assign acc = s3_pv + s3_pw;
  assign accr = acc + 38'd32;
  assign t = accr[37:6] + 32'h2000_0000;

  poterm_pkg::rot_cell_t s4;
  always_ff @(posedge clk) begin
    if (en) begin
      s4.x <= 34'(poterm_pkg::CordicGainInv);
      s4.y <= '0;
      s4.z <= 34'({2'b00, t[29:0]}) - 34'sh2000_0000;
      s4.quad <= t[31:30];
      s4.horizon <= s3_h;
    end
  end

  poterm_pkg::rot_cell_t rc [0:poterm_pkg::CordicSteps];
  assign rc[0] = s4;

  for (genvar g = 0; g < poterm_pkg::CordicSteps; g++) begin : g_rot
    poterm_rot_cell #(.Step(g)) u_cell (
      .clk(clk), .en(en), .din(rc[g]), .dout(rc[g+1])
    );
  end

  // quadrant fold, round and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
    logic signed [34:0] r;
    begin
      r = (v + 35'sd16384) >>> 15;
      if (r > 35'sd32767) return 16'sh7fff;
      else if (r < -35'sd32768) return 16'sh8000;
      else return r[15:0];
    end
  endfunction

  logic signed [34:0] oc, os, c, s;
  always_comb begin
    c = 35'(rc[poterm_pkg::CordicSteps].x);
    s = 35'(rc[poterm_pkg::CordicSteps].y);
    case (rc[poterm_pkg::CordicSteps].quad)
      2'd0: begin oc = c;  os = s;  end
      2'd1: begin oc = -s; os = c;  end
      2'd2: begin oc = -c; os = -s; end
      default: begin oc = s; os = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.gain_real <= to_q15(oc);
      out_data.gain_imag <= to_q15(os);
      out_data.beyond_horizon <= rc[poterm_pkg::CordicSteps].horizon;
    end
  end

  // a stalled result holds its place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  // input is only refused while the output is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  // an accepted item leaves the first stage valid
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item lost");
endmodule
`default_nettype wire

// ===== rtl/core/poterm_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poterm_sqrt_cell #(
  parameter int Step = 0
) (
  input  wire                      clk,
  input  wire                      en,
  input  wire poterm_pkg::sqrt_cell_t din,
  output poterm_pkg::sqrt_cell_t   dout
);
  localparam logic [61:0] Bit = 62'd1 << (60 - 2 * Step);

  poterm_pkg::sqrt_cell_t nxt;

  always_comb begin
    nxt = din;
    if (din.rem_a >= din.res_a + Bit) begin
      nxt.rem_a = din.rem_a - (din.res_a + Bit);
      nxt.res_a = (din.res_a >> 1) + Bit;
    end else begin
      nxt.res_a = din.res_a >> 1;
    end
    if (din.rem_b >= din.res_b + Bit) begin
      nxt.rem_b = din.rem_b - (din.res_b + Bit);
      nxt.res_b = (din.res_b >> 1) + Bit;
    end else begin
      nxt.res_b = din.res_b >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/poterm_rot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poterm_rot_cell #(
  parameter int Step = 0
) (
  input  wire                     clk,
  input  wire                     en,
  input  wire poterm_pkg::rot_cell_t din,
  output poterm_pkg::rot_cell_t   dout
);
  poterm_pkg::rot_cell_t nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;

  always_comb begin
    xs = din.x >>> Step;
    ys = din.y >>> Step;
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - poterm_pkg::turn_atan(Step);
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + poterm_pkg::turn_atan(Step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire
